[hw/rtl/clcd4_pkg.sv]
`default_nettype none

package clcd4_pkg;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // field and register widths
  localparam int unsigned TICK_W      = 20;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_USED_W  = 9;

  // number of nibbles in the init sequence
  localparam logic [STEP_W-1:0] INIT_STEPS = STEP_W'(12);

  // register reset values
  localparam logic [7:0]        RST_ENABLE_HIGH = 8'd1;
  localparam logic [15:0]       RST_SETTLE      = 16'd50;
  localparam logic [TICK_W-1:0] RST_POWER_UP    = TICK_W'(50000);
  localparam logic [15:0]       RST_FIRST_WAIT  = 16'd5000;
  localparam logic [15:0]       RST_SHORT_WAIT  = 16'd150;
  localparam logic [15:0]       RST_CLEAR_WAIT  = 16'd2000;

  typedef enum logic [2:0] {
    PH_POWER  = 3'd0,
    PH_HIGH   = 3'd1,
    PH_SETTLE = 3'd2,
    PH_EXTRA  = 3'd3,
    PH_IDLE   = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_HIGH = 3'd0,
    CFG_SETTLE      = 3'd1,
    CFG_POWER_UP    = 3'd2,
    CFG_FIRST_WAIT  = 3'd3,
    CFG_SHORT_WAIT  = 3'd4,
    CFG_CLEAR_WAIT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_FIRST = 2'd1,
    WAIT_SHORT = 2'd2,
    WAIT_CLEAR = 2'd3
  } wait_sel_t;

  typedef enum logic {
    ITEM_TICK  = 1'b0,
    ITEM_WRITE = 1'b1
  } item_kind_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    item_kind_t kind;
    logic [7:0] byte_value;
    logic       register_select;
  } item_t;

  // one result item
  typedef struct packed {
    logic       write_rejected;
    logic       write_accepted;
    logic       busy_res;
    logic [3:0] data_pins;
    logic       enable_pin;
    logic       rs_pin;
  } result_t;

  // nibble driven at each init step: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06
  function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
    logic [3:0] nib;
    unique case (step)
      5'd0, 5'd1, 5'd2: nib = 4'h3;
      5'd3, 5'd4:       nib = 4'h2;
      5'd5:             nib = 4'h8;
      5'd7:             nib = 4'hC;
      5'd9:             nib = 4'h1;
      5'd11:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  // extra wait after each init step
  function automatic wait_sel_t init_wait(input logic [STEP_W-1:0] step);
    wait_sel_t sel;
    unique case (step)
      5'd0:             sel = WAIT_FIRST;
      5'd1, 5'd2, 5'd3: sel = WAIT_SHORT;
      5'd9:             sel = WAIT_CLEAR;
      default:          sel = WAIT_NONE;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/clcd4_front.sv]
`default_nettype none

module clcd4_front #(
  parameter int unsigned QueueDepth = clcd4_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [clcd4_pkg::IN_TDATA_W-1:0]    in_data,
  input  wire logic [clcd4_pkg::IN_TUSER_W-1:0]    in_user,
  output logic                                     q_valid,
  output clcd4_pkg::item_t                         q_item,
  input  wire logic                                q_pop
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  clcd4_pkg::item_t entries [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  clcd4_pkg::item_t item_in;
  logic             push;

  // classify the incoming transaction
  always_comb begin
    item_in.kind            = in_user[0] ? clcd4_pkg::ITEM_WRITE : clcd4_pkg::ITEM_TICK;
    item_in.byte_value      = in_data;
    item_in.register_select = in_user[1];
  end

  assign in_ready = (count != DepthCnt);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthCnt)
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

[hw/rtl/clcd4_back.sv]
`default_nettype none

module clcd4_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [clcd4_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [clcd4_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                q_valid,
  input  wire clcd4_pkg::item_t                    q_item,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output clcd4_pkg::result_t                       out_res
);

  localparam int unsigned TW = clcd4_pkg::TICK_W;
  localparam int unsigned SW = clcd4_pkg::STEP_W;

  // timing registers
  logic [7:0]    enable_high;
  logic [15:0]   settle;
  logic [TW-1:0] power_up;
  logic [15:0]   first_wait;
  logic [15:0]   short_wait;
  logic [15:0]   clear_wait;

  // sequencer state
  clcd4_pkg::phase_t phase, phase_next;
  logic [SW-1:0] init_step, init_step_next;
  logic [TW-1:0] tick_count, tick_count_next;
  logic [7:0]    pending_byte, pending_byte_next;
  logic          second_nibble, second_nibble_next;
  logic          rs_level, rs_level_next;
  logic          enable_level, enable_level_next;
  logic [3:0]    nibble_out, nibble_out_next;

  logic               advance;
  logic [TW-1:0]      count_inc;
  logic [TW-1:0]      limit;
  logic [TW-1:0]      extra_lim;
  logic               reached;
  logic               step_valid;
  logic [SW-1:0]      step_inc;
  logic               do_next_step;
  clcd4_pkg::wait_sel_t wait_sel;
  clcd4_pkg::result_t res_next;

  assign advance = q_valid && (!out_valid || out_ready);
  assign q_pop   = advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_high <= clcd4_pkg::RST_ENABLE_HIGH;
      settle      <= clcd4_pkg::RST_SETTLE;
      power_up    <= clcd4_pkg::RST_POWER_UP;
      first_wait  <= clcd4_pkg::RST_FIRST_WAIT;
      short_wait  <= clcd4_pkg::RST_SHORT_WAIT;
      clear_wait  <= clcd4_pkg::RST_CLEAR_WAIT;
    end else if (cfg_wen) begin
      unique case (clcd4_pkg::cfg_idx_t'(cfg_addr))
        clcd4_pkg::CFG_ENABLE_HIGH: enable_high <= cfg_wdata[7:0];
        clcd4_pkg::CFG_SETTLE:      settle      <= cfg_wdata[15:0];
        clcd4_pkg::CFG_POWER_UP:    power_up    <= cfg_wdata[TW-1:0];
        clcd4_pkg::CFG_FIRST_WAIT:  first_wait  <= cfg_wdata[15:0];
        clcd4_pkg::CFG_SHORT_WAIT:  short_wait  <= cfg_wdata[15:0];
        clcd4_pkg::CFG_CLEAR_WAIT:  clear_wait  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // extra wait selected by the current init step
  always_comb begin
    step_valid = (init_step < clcd4_pkg::INIT_STEPS);
    wait_sel   = step_valid ? clcd4_pkg::init_wait(init_step) : clcd4_pkg::WAIT_NONE;
    unique case (wait_sel)
      clcd4_pkg::WAIT_FIRST: extra_lim = TW'(first_wait);
      clcd4_pkg::WAIT_SHORT: extra_lim = TW'(short_wait);
      clcd4_pkg::WAIT_CLEAR: extra_lim = TW'(clear_wait);
      default:               extra_lim = '0;
    endcase
  end

  // phase limit and compare; a zero limit counts as one tick
  always_comb begin
    count_inc = tick_count + 1'b1;
    unique case (phase)
      clcd4_pkg::PH_POWER:  limit = power_up;
      clcd4_pkg::PH_HIGH:   limit = TW'(enable_high);
      clcd4_pkg::PH_SETTLE: limit = TW'(settle);
      clcd4_pkg::PH_EXTRA:  limit = extra_lim;
      default:              limit = '0;
    endcase
    reached = (count_inc >= ((limit == '0) ? TW'(1) : limit));
  end

  // next state
  always_comb begin
    phase_next         = phase;
    init_step_next     = init_step;
    tick_count_next    = tick_count;
    pending_byte_next  = pending_byte;
    second_nibble_next = second_nibble;
    rs_level_next      = rs_level;
    enable_level_next  = enable_level;
    nibble_out_next    = nibble_out;
    do_next_step       = 1'b0;
    step_inc           = init_step + 1'b1;

    if (q_item.kind == clcd4_pkg::ITEM_WRITE) begin
      // byte write, taken only when idle
      if (phase == clcd4_pkg::PH_IDLE) begin
        pending_byte_next  = q_item.byte_value;
        rs_level_next      = q_item.register_select;
        second_nibble_next = 1'b0;
        nibble_out_next    = q_item.byte_value[7:4];
        enable_level_next  = 1'b1;
        phase_next         = clcd4_pkg::PH_HIGH;
        tick_count_next    = '0;
      end
    end else if (phase != clcd4_pkg::PH_IDLE) begin
      tick_count_next = count_inc;
      unique case (phase)
        clcd4_pkg::PH_POWER: begin
          if (reached) begin
            init_step_next    = '0;
            rs_level_next     = 1'b0;
            nibble_out_next   = clcd4_pkg::init_nibble('0);
            enable_level_next = 1'b1;
            phase_next        = clcd4_pkg::PH_HIGH;
            tick_count_next   = '0;
          end
        end
        clcd4_pkg::PH_HIGH: begin
          if (reached) begin
            enable_level_next = 1'b0;
            phase_next        = clcd4_pkg::PH_SETTLE;
            tick_count_next   = '0;
          end
        end
        clcd4_pkg::PH_SETTLE: begin
          if (reached) begin
            if (step_valid) begin
              if (wait_sel != clcd4_pkg::WAIT_NONE) begin
                phase_next      = clcd4_pkg::PH_EXTRA;
                tick_count_next = '0;
              end else begin
                do_next_step = 1'b1;
              end
            end else if (!second_nibble) begin
              second_nibble_next = 1'b1;
              nibble_out_next    = pending_byte[3:0];
              enable_level_next  = 1'b1;
              phase_next         = clcd4_pkg::PH_HIGH;
              tick_count_next    = '0;
            end else begin
              phase_next      = clcd4_pkg::PH_IDLE;
              tick_count_next = '0;
            end
          end
        end
        clcd4_pkg::PH_EXTRA: begin
          if (reached) begin
            do_next_step = 1'b1;
          end
        end
        default: begin
          phase_next      = clcd4_pkg::PH_IDLE;
          tick_count_next = '0;
        end
      endcase

      // move to the next init nibble or finish the sequence
      if (do_next_step) begin
        if (step_inc >= clcd4_pkg::INIT_STEPS) begin
          init_step_next  = clcd4_pkg::INIT_STEPS;
          phase_next      = clcd4_pkg::PH_IDLE;
          tick_count_next = '0;
        end else begin
          init_step_next    = step_inc;
          nibble_out_next   = clcd4_pkg::init_nibble(step_inc);
          enable_level_next = 1'b1;
          phase_next        = clcd4_pkg::PH_HIGH;
          tick_count_next   = '0;
        end
      end
    end
  end

  // result fields
  always_comb begin
    res_next.rs_pin         = rs_level_next;
    res_next.enable_pin     = enable_level_next;
    res_next.data_pins      = nibble_out_next;
    res_next.busy_res       = (phase_next != clcd4_pkg::PH_IDLE);
    res_next.write_accepted = (q_item.kind == clcd4_pkg::ITEM_WRITE)
                              && (phase == clcd4_pkg::PH_IDLE);
    res_next.write_rejected = (q_item.kind == clcd4_pkg::ITEM_WRITE)
                              && (phase != clcd4_pkg::PH_IDLE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= clcd4_pkg::PH_POWER;
      init_step     <= '0;
      tick_count    <= '0;
      pending_byte  <= '0;
      second_nibble <= 1'b0;
      rs_level      <= 1'b0;
      enable_level  <= 1'b0;
      nibble_out    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      init_step     <= init_step_next;
      tick_count    <= tick_count_next;
      pending_byte  <= pending_byte_next;
      second_nibble <= second_nibble_next;
      rs_level      <= rs_level_next;
      enable_level  <= enable_level_next;
      nibble_out    <= nibble_out_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

`ifndef SYNTH
  a_enable_phase: assert property (@(posedge clk) disable iff (rst)
    enable_level |-> (phase == clcd4_pkg::PH_HIGH))
    else $error("enable high outside the strobe phase");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == clcd4_pkg::PH_IDLE) |-> (tick_count == '0))
    else $error("tick count running while idle");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    init_step <= clcd4_pkg::INIT_STEPS)
    else $error("init step past end of sequence");

  a_acc_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.write_accepted && out_res.write_rejected))
    else $error("write both accepted and rejected");
`endif

endmodule

`default_nettype wire

[hw/rtl/char_lcd_4bit_interface_unit.sv]
// path: a result passes through the queue entry and then the sequencer output register
// after its input transaction is accepted
// throughput: one item per clock while the result side does not stall; the sequencer updates its state once per item
// a two-entry queue parts the input side from the sequencer, an output register
// parts the sequencer from the result side, so each side may stall on its own
// reset: timing registers return to defaults, queue empties, sequencer restarts
// the power-up wait with all pins low
`default_nettype none

module char_lcd_4bit_interface_unit #(
  parameter int unsigned QueueDepth = clcd4_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [clcd4_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [clcd4_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // byte_value
  input  wire logic [clcd4_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation, register_select
  input  wire logic [clcd4_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // rs_pin, enable_pin, data_pins[3:0], busy_res, write_accepted, write_rejected
  output logic [clcd4_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  logic               q_valid;
  logic               q_pop;
  clcd4_pkg::item_t   q_item;
  clcd4_pkg::result_t out_res;

  // front: classify and queue transactions
  clcd4_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_data (s_axis_tdata),
    .in_user (s_axis_tuser),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back: init and write sequencer
  clcd4_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res)
  );

  // pack result, zero filled to whole bytes
  assign m_axis_tdata = {{(clcd4_pkg::OUT_TDATA_W - clcd4_pkg::OUT_USED_W){1'b0}}, out_res};

endmodule

`default_nettype wire

[tb/tb_char_lcd_4bit_interface_unit.sv]
`timescale 1ns / 1ps

module tb_char_lcd_4bit_interface_unit;
  import clcd4_pkg::*;

  // nibble per init step, step 0 in the low bits: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06
  localparam logic [47:0] SEQ_NIBS  = 48'h6010C0822333;
  // extra wait per init step, two bits each, step 0 in the low bits
  localparam logic [23:0] SEQ_WAITS = 24'h0C00A9;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // byte_value
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // operation, register_select
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // rs_pin, enable_pin, data_pins[3:0], busy_res, write_accepted, write_rejected
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // one row of the directed part: a register write or a run of identical items
  typedef struct packed {
    logic        reg_row;
    cfg_idx_t    reg_idx;
    logic [19:0] reg_val;
    item_kind_t  kind;
    logic [7:0]  byt;
    logic        rsel;
    logic [7:0]  reps;
    logic        typed;
    result_t     want;
  } dir_row_t;

  // timing registers as the block should hold them
  logic [7:0]  reg_en_high  = 8'd1;
  logic [15:0] reg_settle   = 16'd50;
  logic [19:0] reg_power_up = 20'd50000;
  logic [15:0] reg_first    = 16'd5000;
  logic [15:0] reg_short    = 16'd150;
  logic [15:0] reg_clear    = 16'd2000;

  // sequencer state and pin levels as the block should hold them
  phase_t      lcd_phase    = PH_POWER;
  logic [4:0]  lcd_step     = '0;
  logic [19:0] lcd_count    = '0;
  logic [7:0]  lcd_byte     = '0;
  logic        lcd_low_half = 1'b0;
  logic        lcd_rs       = 1'b0;
  logic        lcd_en       = 1'b0;
  logic [3:0]  lcd_nib      = '0;

  result_t     pin_results[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  char_lcd_4bit_interface_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // a zero limit counts as one tick
  function automatic logic reached(input logic [19:0] cnt, input logic [19:0] lim);
    return cnt >= ((lim == '0) ? 20'd1 : lim);
  endfunction

  function automatic wait_sel_t seq_wait(input logic [4:0] step);
    return wait_sel_t'(SEQ_WAITS[2*step +: 2]);
  endfunction

  function automatic logic [19:0] extra_wait();
    logic [19:0] lim;
    lim = '0;
    if (lcd_step < INIT_STEPS) begin
      case (seq_wait(lcd_step))
        WAIT_FIRST: lim = {4'b0, reg_first};
        WAIT_SHORT: lim = {4'b0, reg_short};
        WAIT_CLEAR: lim = {4'b0, reg_clear};
        default:    lim = '0;
      endcase
    end
    return lim;
  endfunction

  function automatic void lcd_strobe(input logic [3:0] nib);
    lcd_nib   = nib;
    lcd_en    = 1'b1;
    lcd_phase = PH_HIGH;
    lcd_count = '0;
  endfunction

  function automatic void next_seq_step();
    lcd_step = lcd_step + 1'b1;
    if (lcd_step >= INIT_STEPS) begin
      lcd_step  = INIT_STEPS;
      lcd_phase = PH_IDLE;
      lcd_count = '0;
    end else begin
      lcd_strobe(SEQ_NIBS[4*lcd_step +: 4]);
    end
  endfunction

  // end of the settle time: extra init wait, next init nibble, low nibble or idle
  function automatic void nibble_done();
    if (lcd_step < INIT_STEPS) begin
      if (seq_wait(lcd_step) != WAIT_NONE) begin
        lcd_phase = PH_EXTRA;
        lcd_count = '0;
      end else begin
        next_seq_step();
      end
    end else if (!lcd_low_half) begin
      lcd_low_half = 1'b1;
      lcd_strobe(lcd_byte[3:0]);
    end else begin
      lcd_phase = PH_IDLE;
      lcd_count = '0;
    end
  endfunction

  function automatic void lcd_tick();
    if (lcd_phase != PH_IDLE) begin
      lcd_count = lcd_count + 1'b1;
      case (lcd_phase)
        PH_POWER: begin
          if (reached(lcd_count, reg_power_up)) begin
            lcd_step = '0;
            lcd_rs   = 1'b0;
            lcd_strobe(SEQ_NIBS[3:0]);
          end
        end
        PH_HIGH: begin
          if (reached(lcd_count, {12'b0, reg_en_high})) begin
            lcd_en    = 1'b0;
            lcd_phase = PH_SETTLE;
            lcd_count = '0;
          end
        end
        PH_SETTLE: begin
          if (reached(lcd_count, {4'b0, reg_settle})) nibble_done();
        end
        PH_EXTRA: begin
          if (reached(lcd_count, extra_wait())) next_seq_step();
        end
        default: begin
          lcd_phase = PH_IDLE;
          lcd_count = '0;
        end
      endcase
    end
  endfunction

  // pin levels after one item
  function automatic result_t lcd_advance(input item_kind_t kind, input logic [7:0] byt,
                                          input logic rsel);
    result_t r;
    r = '0;
    if (kind == ITEM_TICK) begin
      lcd_tick();
    end else if (lcd_phase == PH_IDLE) begin
      lcd_byte     = byt;
      lcd_rs       = rsel;
      lcd_low_half = 1'b0;
      lcd_strobe(byt[7:4]);
      r.write_accepted = 1'b1;
    end else begin
      r.write_rejected = 1'b1;
    end
    r.rs_pin     = lcd_rs;
    r.enable_pin = lcd_en;
    r.data_pins  = lcd_nib;
    r.busy_res   = (lcd_phase != PH_IDLE);
    return r;
  endfunction

  function automatic result_t pins(input logic rs, input logic en, input logic [3:0] d,
                                   input logic busy, input logic acc, input logic rej);
    result_t r;
    r.rs_pin         = rs;
    r.enable_pin     = en;
    r.data_pins      = d;
    r.busy_res       = busy;
    r.write_accepted = acc;
    r.write_rejected = rej;
    return r;
  endfunction

  function automatic dir_row_t item_row(input item_kind_t kind, input logic [7:0] byt,
                                        input logic rsel, input logic [7:0] reps);
    dir_row_t r;
    r      = '0;
    r.kind = kind;
    r.byt  = byt;
    r.rsel = rsel;
    r.reps = reps;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input item_kind_t kind, input logic [7:0] byt,
                                         input logic rsel, input result_t want);
    dir_row_t r;
    r       = item_row(kind, byt, rsel, 8'd1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input cfg_idx_t idx, input logic [19:0] val);
    dir_row_t r;
    r         = '0;
    r.reg_row = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // register write, mirrored into the expected timing
  task automatic set_reg(input cfg_idx_t idx, input logic [19:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_ENABLE_HIGH: reg_en_high  = val[7:0];
      CFG_SETTLE:      reg_settle   = val[15:0];
      CFG_POWER_UP:    reg_power_up = val;
      CFG_FIRST_WAIT:  reg_first    = val[15:0];
      CFG_SHORT_WAIT:  reg_short    = val[15:0];
      CFG_CLEAR_WAIT:  reg_clear    = val[15:0];
      default: ;
    endcase
  endtask

  // one input transaction; the expectation is queued at the accepting edge
  task automatic send_item(input item_kind_t kind, input logic [7:0] byt, input logic rsel,
                           input logic typed, input result_t want);
    result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= byt;
    s_axis_tuser  <= {rsel, kind};
    do @(posedge clk); while (!s_axis_tready);
    pred = lcd_advance(kind, byt, rsel);
    pin_results.push_back(typed ? want : pred);
  endtask

  // stop sending and let every result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pin_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pin_results.size() == 0) begin
        $error("result %h with no expectation waiting", m_axis_tdata);
        mismatches++;
      end else begin
        want = pin_results.pop_front();
        got  = result_t'(m_axis_tdata[8:0]);
        check_field("rs_pin", 32'(want.rs_pin), 32'(got.rs_pin));
        check_field("enable_pin", 32'(want.enable_pin), 32'(got.enable_pin));
        check_field("data_pins", 32'(want.data_pins), 32'(got.data_pins));
        check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        check_field("write_accepted", 32'(want.write_accepted),
                    32'(got.write_accepted));
        check_field("write_rejected", 32'(want.write_rejected),
                    32'(got.write_rejected));
        check_field("tdata padding", 0, 32'(m_axis_tdata[OUT_TDATA_W-1:9]));
      end
    end
  end

  initial begin
    dir_row_t    row;
    int unsigned ph;
    int unsigned n;
    int unsigned wr_pct;
    logic [7:0]  hi;
    logic [15:0] st;
    item_kind_t  kind;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // still in the power-up wait: busy, pins low, writes refused
    dir_rows.push_back(typed_row(ITEM_TICK, 8'h00, 1'b0,
                                 pins(1'b0, 1'b0, 4'h0, 1'b1, 1'b0, 1'b0)));
    dir_rows.push_back(typed_row(ITEM_WRITE, 8'hA5, 1'b1,
                                 pins(1'b0, 1'b0, 4'h0, 1'b1, 1'b0, 1'b1)));
    // fastest timing, zero settle counts as one tick
    dir_rows.push_back(reg_row(CFG_ENABLE_HIGH, 20'd1));
    dir_rows.push_back(reg_row(CFG_SETTLE, 20'd0));
    dir_rows.push_back(reg_row(CFG_POWER_UP, 20'd1));
    dir_rows.push_back(reg_row(CFG_FIRST_WAIT, 20'd1));
    dir_rows.push_back(reg_row(CFG_SHORT_WAIT, 20'd1));
    dir_rows.push_back(reg_row(CFG_CLEAR_WAIT, 20'd1));
    // whole init sequence
    dir_rows.push_back(item_row(ITEM_TICK, 8'h00, 1'b0, 8'd30));
    // command write, then a write while busy
    dir_rows.push_back(typed_row(ITEM_WRITE, 8'h00, 1'b0,
                                 pins(1'b0, 1'b1, 4'h0, 1'b1, 1'b1, 1'b0)));
    dir_rows.push_back(typed_row(ITEM_WRITE, 8'h3C, 1'b1,
                                 pins(1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(ITEM_TICK, 8'hFF, 1'b1, 8'd4));
    // data write, then idle with RS and data held
    dir_rows.push_back(typed_row(ITEM_WRITE, 8'hFF, 1'b1,
                                 pins(1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 1'b0)));
    dir_rows.push_back(item_row(ITEM_TICK, 8'h00, 1'b0, 8'd4));
    dir_rows.push_back(typed_row(ITEM_TICK, 8'h00, 1'b0,
                                 pins(1'b1, 1'b0, 4'hF, 1'b0, 1'b0, 1'b0)));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.reg_row) begin
        drain();
        set_reg(row.reg_idx, row.reg_val);
      end else begin
        repeat (row.reps) send_item(row.kind, row.byt, row.rsel, row.typed, row.want);
      end
    end

    // random phases, each with its own timing and idling
    for (ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          hi = 8'd1;
          st = 16'd1;
        end
        2: begin
          hi = 8'd255;
          st = 16'd65535;
        end
        3: begin
          hi = 8'd0;
          st = 16'd0;
        end
        default: begin
          hi = 8'($urandom_range(1, 5));
          st = 16'($urandom_range(0, 8));
        end
      endcase
      set_reg(CFG_ENABLE_HIGH, {12'b0, hi});
      set_reg(CFG_SETTLE, {4'b0, st});
      if (ph == 2) begin
        set_reg(CFG_POWER_UP, 20'hFFFFF);
        set_reg(CFG_FIRST_WAIT, 20'h0FFFF);
        set_reg(CFG_SHORT_WAIT, 20'h0FFFF);
        set_reg(CFG_CLEAR_WAIT, 20'h0FFFF);
      end else begin
        set_reg(CFG_POWER_UP, 20'($urandom_range(0, 20'hFFFFF)));
        set_reg(CFG_FIRST_WAIT, 20'($urandom_range(0, 16'hFFFF)));
        set_reg(CFG_SHORT_WAIT, 20'($urandom_range(0, 16'hFFFF)));
        set_reg(CFG_CLEAR_WAIT, 20'($urandom_range(0, 16'hFFFF)));
      end
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      // mostly writes when idle, a few writes into a busy block
      for (n = 0; n < 50; n++) begin
        wr_pct = (lcd_phase == PH_IDLE) ? 60 : 8;
        kind   = ($urandom_range(0, 99) < wr_pct) ? ITEM_WRITE : ITEM_TICK;
        send_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("char_lcd_4bit_interface_unit regression: pass");
    end else begin
      $display("char_lcd_4bit_interface_unit regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("char_lcd_4bit_interface_unit regression: fail");
    $finish;
  end

endmodule

[char_lcd_4bit_interface_unit.f]
hw/rtl/clcd4_pkg.sv
hw/rtl/clcd4_front.sv
hw/rtl/clcd4_back.sv
hw/rtl/char_lcd_4bit_interface_unit.sv
tb/tb_char_lcd_4bit_interface_unit.sv
